/* hw/rtl/sha_pkg.sv */
// Package of types and constants for the SHA-256 stream hasher.
package sha_pkg;

   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned WORDS = 16;
   localparam int unsigned ROUNDS = 64;
   localparam int unsigned PAD_LIMIT = 55;

   typedef enum logic [1:0] {
      FUNC_ABSORB = 2'd0,
      FUNC_ABSORB_FINISH = 2'd1,
      FUNC_FINISH = 2'd2,
      FUNC_UNUSED = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LOAD,
      PH_READ,
      PH_ROUND
   } phase_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } comp_ctrl_type;

   localparam logic [31:0] START_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

/* hw/rtl/sha_ifs.sv */
// Handshake interfaces for the request and response channels.
interface sha_req_if import sha_pkg::*; ();
   logic valid;
   logic ready;
   logic [1:0] func;
   logic [7:0] data_byte;
   modport source (output valid, func, data_byte, input ready);
   modport sink (input valid, func, data_byte, output ready);
endinterface

interface sha_rsp_if import sha_pkg::*; ();
   logic valid;
   logic ready;
   logic [31:0] digest_word;
   logic [2:0] word_index;
   logic last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* hw/rtl/sha_core.sv */
// SHA-256 compression engine: rounds computed in turn over a schedule memory.
module sha_core import sha_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [31:0] load_word,
   output logic [3:0] load_addr,
   input  logic [31:0] hash_in [8],
   output logic [31:0] hash_out [8],
   output comp_ctrl_type ctrl
);

   logic [31:0] wmem [16];
   logic [6:0] cnt_ff, cnt_in;
   phase_type ph_ff, ph_in;
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] r15_ff, r2_ff, r16_ff, r7_ff;
   logic [31:0] wt, sg0, sg1, s1, s0, ch, mj, t1, t2;
   logic [5:0] t;
   logic done_ff, done_in;

   // The load phase writes each word in the cycle after its buffer read, so its count runs to WORDS.
   // Each round then has two steps: a schedule read and the compute.
   assign t = cnt_ff[5:0];
   assign load_addr = cnt_ff[3:0];

   always_ff @(posedge clock) begin
      if (ph_ff == PH_LOAD && cnt_ff != 7'd0) begin
         wmem[4'(cnt_ff - 7'd1)] <= load_word;
      end
      if (ph_ff == PH_ROUND && t >= 6'd16) begin
         wmem[t[3:0]] <= wt;
      end
      r15_ff <= wmem[4'(t - 6'd15)];
      r2_ff <= wmem[4'(t - 6'd2)];
      r16_ff <= wmem[t[3:0]];
      r7_ff <= wmem[4'(t - 6'd7)];
   end

   always_comb begin
      sg0 = rotr(r15_ff, 7) ^ rotr(r15_ff, 18) ^ (r15_ff >> 3);
      sg1 = rotr(r2_ff, 17) ^ rotr(r2_ff, 19) ^ (r2_ff >> 10);
      wt = (t < 6'd16) ? r16_ff : r16_ff + sg0 + r7_ff + sg1;
      s1 = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1 = v_ff[7] + s1 + ch + ROUND_CONST[t] + wt;
      s0 = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      mj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2 = s0 + mj;
   end

   always_comb begin
      ph_in = ph_ff;
      unique case (ph_ff)
         PH_IDLE: begin
            if (start) ph_in = PH_LOAD;
         end
         PH_LOAD: begin
            if (cnt_ff == 7'(WORDS)) ph_in = PH_READ;
         end
         PH_READ: ph_in = PH_ROUND;
         PH_ROUND: begin
            if (cnt_ff == 7'(ROUNDS - 1)) ph_in = PH_IDLE;
            else ph_in = PH_READ;
         end
         default: ph_in = PH_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      v_in = v_ff;
      done_in = 1'b0;
      unique case (ph_ff)
         PH_IDLE: begin
            if (start) cnt_in = '0;
         end
         PH_LOAD: begin
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(WORDS)) begin
               cnt_in = '0;
               v_in = hash_in;
            end
         end
         PH_READ: ;
         PH_ROUND: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(ROUNDS - 1)) done_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE;
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in;
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
      v_ff <= v_in;
   end

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         hash_out[j] = hash_in[j] + v_ff[j];
      end
   end

   assign ctrl.start = start;
   assign ctrl.busy = (ph_ff != PH_IDLE);
   assign ctrl.done = done_ff;

endmodule

/* hw/rtl/sha256_stream_hasher.sv */
// Top level of the SHA-256 stream hasher: byte buffer, padding and digest output.
//
// Channel  Dir  Moves
// req      in   one word: func and data_byte
// rsp      out  one word: digest_word, word_index, last_word
//
// An absorbed byte is written to the buffer when accepted; the byte completing a block
// also starts a compression, run by the engine one round at a time on its schedule memory.
// A finish costs one or two padding passes, each followed by a compression, and then
// the eight digest words are output.
// Reset is synchronous and restores the initial hash; req is not ready while busy.
// A stalled rsp holds the digest word and the engine waits.
module sha256_stream_hasher import sha_pkg::*; (
   input logic clock,
   input logic reset,
   sha_req_if.sink req,
   sha_rsp_if.source rsp
);

   logic [31:0] buf_mem [WORDS];
   logic [31:0] hash_ff [8];
   logic [31:0] hash_in [8];
   logic [31:0] hash_new [8];
   logic [5:0] count_ff, count_in;
   logic [63:0] len_ff, len_in;
   state_type state_ff, state_in;
   logic finish_ff, finish_in;
   logic second_ff, second_in;
   logic tail_ff, tail_in;
   logic [5:0] pad_ff, pad_in;
   logic [2:0] oidx_ff, oidx_in;
   logic buf_we;
   logic [5:0] buf_wa;
   logic [7:0] buf_wd;
   logic [3:0] load_addr;
   logic [31:0] load_word_ff;
   logic core_start;
   comp_ctrl_type ctrl;
   logic accept;

   assign accept = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_wa[5:2]][{~buf_wa[1:0], 3'b000} +: 8] <= buf_wd;
      end
      load_word_ff <= buf_mem[load_addr];
   end

   sha_core u_core (
      .clock(clock), .reset(reset), .start(core_start), .load_word(load_word_ff),
      .load_addr(load_addr), .hash_in(hash_ff), .hash_out(hash_new), .ctrl(ctrl)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.func == FUNC_ABSORB && count_ff == 6'd63) state_in = ST_LOAD;
               else if (req.func == FUNC_ABSORB_FINISH && count_ff == 6'd63)
                  state_in = ST_LOAD;
               else if (req.func == FUNC_ABSORB_FINISH || req.func == FUNC_FINISH)
                  state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (pad_ff == 6'd63) state_in = ST_LOAD;
         end
         ST_LOAD: state_in = ST_ROUND;
         ST_ROUND: begin
            if (ctrl.done) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!finish_ff) state_in = ST_IDLE;
            else if (second_ff || tail_ff) state_in = ST_PAD;
            else state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp.ready && oidx_ff == 3'd7) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      len_in = len_ff;
      finish_in = finish_ff;
      second_in = second_ff;
      tail_in = tail_ff;
      pad_in = pad_ff;
      oidx_in = oidx_ff;
      hash_in = hash_ff;
      buf_we = 1'b0;
      buf_wa = count_ff;
      buf_wd = req.data_byte;
      core_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            oidx_in = '0;
            if (accept && req.func != FUNC_UNUSED) begin
               finish_in = (req.func != FUNC_ABSORB);
               second_in = 1'b0;
               tail_in = (req.func == FUNC_ABSORB_FINISH && count_ff == 6'd63);
               pad_in = count_ff;
               if (req.func != FUNC_FINISH) begin
                  buf_we = 1'b1;
                  len_in = len_ff + 64'd8;
                  count_in = count_ff + 6'd1;
                  pad_in = count_ff + 6'd1;
               end
            end
         end
         ST_PAD: begin
            // Pads from the byte after the data; the length goes in the last
            // eight bytes unless the marker pushed it into a second block.
            buf_we = 1'b1;
            buf_wa = pad_ff;
            if (pad_ff == count_ff && !second_ff) buf_wd = 8'h80;
            else if (pad_ff >= 6'd56 && !(count_ff > 6'(PAD_LIMIT) && !second_ff))
               buf_wd = len_ff[{~pad_ff[2:0], 3'b111} -: 8];
            else buf_wd = 8'h00;
            pad_in = pad_ff + 6'd1;
            if (pad_ff == 6'd63) begin
               if (count_ff > 6'(PAD_LIMIT) && !second_ff) second_in = 1'b1;
               else second_in = 1'b0;
            end
         end
         ST_LOAD: core_start = 1'b1;
         ST_UPDATE: begin
            hash_in = hash_new;
            if (second_ff) begin
               pad_in = '0;
               count_in = 6'd63;
            end
            if (tail_ff) begin
               pad_in = '0;
               tail_in = 1'b0;
            end
            if (!finish_ff) count_in = '0;
         end
         ST_EMIT: begin
            if (rsp.ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  hash_in = START_HASH;
                  count_in = '0;
                  len_in = '0;
                  finish_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hash_ff <= START_HASH;
         count_ff <= '0;
         len_ff <= '0;
         finish_ff <= 1'b0;
         second_ff <= 1'b0;
         tail_ff <= 1'b0;
         oidx_ff <= '0;
      end else begin
         state_ff <= state_in;
         hash_ff <= hash_in;
         count_ff <= count_in;
         len_ff <= len_in;
         finish_ff <= finish_in;
         second_ff <= second_in;
         tail_ff <= tail_in;
         oidx_ff <= oidx_in;
      end
      pad_ff <= pad_in;
   end

   assign rsp.valid = (state_ff == ST_EMIT);
   assign rsp.digest_word = hash_ff[oidx_ff];
   assign rsp.word_index = oidx_ff;
   assign rsp.last_word = (oidx_ff == 3'd7);

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl.busy |-> !accept) else $error("word accepted during compression");
   a_emit_idle_core: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !ctrl.busy) else $error("digest shown while engine busy");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.last_word) |=> (state_ff == ST_IDLE))
      else $error("no return to idle after last word");
`endif

endmodule
